[rtl/core/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_ROW0  = 2'd1,
        BR_ROW1  = 2'd2,
        BR_ROW2  = 2'd3
    } branch_t;

endpackage

[rtl/core/rotation_matrix_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// converts a fixed point rotation matrix into a quaternion
// ----------------------------------------------------------------------------
// One matrix word is taken and one quaternion word leaves per clock unless the
// output stalls. A word passes the stage 0 register, RH square root cells, NW
// divider cells and the output register (RH = (DATA_WIDTH + FRAC_BITS + 6)/2,
// NW = DATA_WIDTH + FRAC_BITS + 3; 18 and 33 with defaults). The chain advances
// only when the output register is free or being taken; stalls freeze every cell.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // elem_00, elem_01, elem_02, elem_10, elem_11, elem_12, elem_20, elem_21, elem_22
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // quat_w, quat_x, quat_y, quat_z, branch_used, degenerate
    output logic [((4*DATA_WIDTH+3+7)/8)*8-1:0] m_tdata
);
    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RADW = DW + 4;
    localparam int RW   = RADW + F + 2;
    localparam int RH   = RW / 2;
    localparam int NW   = DW + 3 + F;
    localparam int SW   = DW + F + 2;
    localparam int LAT  = RH + NW + 1;
    localparam int OW   = ((4*DW+3+7)/8)*8;

    typedef struct packed {
        logic                   degen;
        logic [1:0]             br;
        logic [2:0]             neg;
    } side_t;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic           m_tvalid_reg;
    logic [OW-1:0]  m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // stage 0: branch select, radicand, differences
    logic signed [DW-1:0] r [9];
    logic signed [RADW-1:0] tr, rad;
    logic signed [RADW-1:0] d [3];
    branch_t brs;
    always_comb begin
        for (int i = 0; i < 9; i++) r[i] = s_tdata[i*DW +: DW];
        tr = RADW'(r[0]) + RADW'(r[4]) + RADW'(r[8]);
        if (tr > 0) begin
            brs = BR_TRACE; rad = tr;
            d[0] = RADW'(r[7]) - RADW'(r[5]);
            d[1] = RADW'(r[2]) - RADW'(r[6]);
            d[2] = RADW'(r[3]) - RADW'(r[1]);
        end else if (r[0] > r[4] && r[0] > r[8]) begin
            brs = BR_ROW0; rad = RADW'(r[0]) - RADW'(r[4]) - RADW'(r[8]);
            d[0] = RADW'(r[7]) - RADW'(r[5]);
            d[1] = RADW'(r[1]) + RADW'(r[3]);
            d[2] = RADW'(r[2]) + RADW'(r[6]);
        end else if (r[4] > r[8]) begin
            brs = BR_ROW1; rad = RADW'(r[4]) - RADW'(r[0]) - RADW'(r[8]);
            d[0] = RADW'(r[2]) - RADW'(r[6]);
            d[1] = RADW'(r[1]) + RADW'(r[3]);
            d[2] = RADW'(r[5]) + RADW'(r[7]);
        end else begin
            brs = BR_ROW2; rad = RADW'(r[8]) - RADW'(r[0]) - RADW'(r[4]);
            d[0] = RADW'(r[3]) - RADW'(r[1]);
            d[1] = RADW'(r[2]) + RADW'(r[6]);
            d[2] = RADW'(r[5]) + RADW'(r[7]);
        end
        rad = rad + RADW'(signed'({1'b0, 1'b1, {F{1'b0}}} ));
        if (rad < 0) rad = '0;
    end

    logic [RW-1:0]  rem0_reg;
    logic [DW:0]    mag_reg [3];
    side_t          side0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg <= RW'(unsigned'(rad)) << F;
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= d[i][RADW-1] ? (DW+1)'(-d[i]) : (DW+1)'(d[i]);
                side0_reg.neg[i] <= d[i][RADW-1];
            end
            side0_reg.br    <= brs;
            side0_reg.degen <= 1'b0;
        end
    end

    // square root chain, carries magnitudes alongside
    logic [RW-1:0] srem  [RH+1];
    logic [RW-1:0] sroot [RH+1];
    logic [DW:0]   smag  [RH+1][3];
    side_t         sside [RH+1];
    assign srem[0]  = rem0_reg;
    assign sroot[0] = '0;
    assign smag[0]  = mag_reg;
    assign sside[0] = side0_reg;

    for (genvar k = 0; k < RH; k++) begin : g_sqrt
        rmq_sqrt_cell #(.RW(RW), .SH(RH-1-k)) u_cell (
            .aclk(aclk), .en(en),
            .rem_in(srem[k]), .root_in(sroot[k]),
            .rem_out(srem[k+1]), .root_out(sroot[k+1])
        );
        logic [DW:0] mag_reg2 [3];
        side_t       side_reg2;
        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg2  <= smag[k];
                side_reg2 <= sside[k];
            end
        end
        assign smag[k+1]  = mag_reg2;
        assign sside[k+1] = side_reg2;
    end

    // divider setup: numerator = mag*2^F + S/2 = mag*2^F + root
    logic [NW-1:0] sden;
    logic [NW-1:0] drem0 [3];
    logic [NW-1:0] dquo0 [3];
    side_t         dside0;
    logic [SW-1:0] lead0;
    always_comb begin
        sden = NW'(sroot[RH]) << 1;
        for (int i = 0; i < 3; i++) begin
            drem0[i] = (NW'(smag[RH][i]) << F) + NW'(sroot[RH]);
            dquo0[i] = '0;
        end
        dside0       = sside[RH];
        dside0.degen = (sroot[RH] == '0);
        lead0        = SW'((sroot[RH] + RW'(1)) >> 1);
    end

    logic [NW-1:0] dden [NW+1];
    logic [NW-1:0] drem [NW+1][3];
    logic [NW-1:0] dquo [NW+1][3];
    side_t         dside [NW+1];
    logic [SW-1:0] dlead [NW+1];
    assign dden[0]  = sden;
    assign drem[0]  = drem0;
    assign dquo[0]  = dquo0;
    assign dside[0] = dside0;
    assign dlead[0] = lead0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        rmq_div_cell #(.NW(NW), .SH(NW-1-k)) u_cell (
            .aclk(aclk), .en(en),
            .den_in(dden[k]), .rem_in(drem[k]), .quo_in(dquo[k]),
            .den_out(dden[k+1]), .rem_out(drem[k+1]), .quo_out(dquo[k+1])
        );
        side_t         side_reg2;
        logic [SW-1:0] lead_reg2;
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg2 <= dside[k];
                lead_reg2 <= dlead[k];
            end
        end
        assign dside[k+1] = side_reg2;
        assign dlead[k+1] = lead_reg2;
    end

    // output assembly with saturation
    logic [NW-1:0]          lim;
    logic signed [DW-1:0]   o [3];
    logic signed [DW-1:0]   q [4];
    logic signed [DW-1:0]   ld;
    side_t                  fs;
    always_comb begin
        fs  = dside[NW];
        lim = NW'(1) << (DW-1);
        for (int i = 0; i < 3; i++) begin
            if (fs.neg[i])
                o[i] = (dquo[NW][i] >= lim) ? DW'(lim) : DW'(-dquo[NW][i]);
            else
                o[i] = (dquo[NW][i] >= lim) ? DW'(lim - NW'(1)) : DW'(dquo[NW][i]);
        end
        ld = (dlead[NW] >= SW'(lim)) ? DW'(lim - NW'(1)) : DW'(dlead[NW]);
        for (int k = 0; k < 4; k++) q[k] = '0;
        if (!fs.degen) begin
            unique case (branch_t'(fs.br))
                BR_TRACE: begin q[0] = ld;   q[1] = o[0]; q[2] = o[1]; q[3] = o[2]; end
                BR_ROW0:  begin q[0] = o[0]; q[1] = ld;   q[2] = o[1]; q[3] = o[2]; end
                BR_ROW1:  begin q[0] = o[0]; q[1] = o[1]; q[2] = ld;   q[3] = o[2]; end
                BR_ROW2:  begin q[0] = o[0]; q[1] = o[1]; q[2] = o[2]; q[3] = ld;   end
                default:  begin q[0] = '0; end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= OW'({fs.degen, fs.br, q[3], q[2], q[1], q[0]});
        end
    end
endmodule

[rtl/core/rmq_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one restoring square root step, result digit per cell, registered
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int RW = 64,
    parameter int SH = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [RW-1:0] root_in,
    output logic [RW-1:0] rem_out,
    output logic [RW-1:0] root_out
);
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] root_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] root_reg;

    always_comb begin
        trial = (root_in << (SH + 1)) | (RW'(1) << (2 * SH));
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = root_in | (RW'(1) << SH);
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

[rtl/core/rmq_div_cell.sv]
// ----------------------------------------------------------------------------
// rmq_div_cell
// one restoring division step for three lanes sharing one divisor
// ----------------------------------------------------------------------------
module rmq_div_cell #(
    parameter int NW = 64,
    parameter int SH = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] den_in,
    input  logic [NW-1:0] rem_in  [3],
    input  logic [NW-1:0] quo_in  [3],
    output logic [NW-1:0] den_out,
    output logic [NW-1:0] rem_out [3],
    output logic [NW-1:0] quo_out [3]
);
    logic [NW-1:0] rem_next [3];
    logic [NW-1:0] quo_next [3];
    logic [NW-1:0] rem_reg  [3];
    logic [NW-1:0] quo_reg  [3];
    logic [NW-1:0] den_reg;
    logic [NW-1:0] lim;
    logic          fits;

    always_comb begin
        lim  = '1;
        fits = ((lim >> SH) >= den_in);
        for (int i = 0; i < 3; i++) begin
            if (fits && ((rem_in[i] >> SH) >= den_in)) begin
                rem_next[i] = rem_in[i] - (den_in << SH);
                quo_next[i] = quo_in[i] | (NW'(1) << SH);
            end else begin
                rem_next[i] = rem_in[i];
                quo_next[i] = quo_in[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_in;
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule

[tb/sv/tb_rotation_matrix_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// self-checking bench for the matrix to quaternion pipeline
// ----------------------------------------------------------------------------
// Matrices go in over the input stream and quaternions come back over the
// result stream. A bit-exact predictor in the bench computes each quaternion
// from the matrix when it is accepted. Each result is compared field by field
// with the oldest pending prediction. The stimulus is a directed set, then
// noisy near-rotation matrices, then a mix of those and fully random words.
// Both sides idle at random, with one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
    import rmq_pkg::*;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int SW = ((9*DW+7)/8)*8;
    localparam int MW = ((4*DW+3+7)/8)*8;
    localparam int LATENCY = 53;
    localparam int N_RANDOM = 1660;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        branch_t              br;
        logic                 degen;
    } quat_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint sat_field(input longint v);
        longint hi;
        hi = (longint'(1) << (DW-1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint div_round(input longint d, input longint unsigned s);
        longint unsigned mag, q, lim;
        mag = (d < 0) ? -d : d;
        q = ((mag << FB) + (s >> 1)) / s;
        lim = longint'(1) << (DW-1);
        if (d < 0) return (q >= lim) ? -longint'(lim) : -longint'(q);
        return (q >= lim) ? longint'(lim - 1) : longint'(q);
    endfunction

    function automatic quat_t matrix_to_quat(input logic [SW-1:0] m);
        longint r[9];
        longint tr, rad, d0, d1, d2, lead;
        longint q[4];
        longint o[3];
        longint unsigned root, s;
        int b, j;
        quat_t res;
        for (int i = 0; i < 9; i++) r[i] = longint'($signed(m[i*DW +: DW]));
        tr = r[0] + r[4] + r[8];
        if (tr > 0) begin
            b = 0; rad = (1 << FB) + tr;
            d0 = r[7] - r[5]; d1 = r[2] - r[6]; d2 = r[3] - r[1];
        end else if (r[0] > r[4] && r[0] > r[8]) begin
            b = 1; rad = (1 << FB) + r[0] - r[4] - r[8];
            d0 = r[7] - r[5]; d1 = r[1] + r[3]; d2 = r[2] + r[6];
        end else if (r[4] > r[8]) begin
            b = 2; rad = (1 << FB) + r[4] - r[0] - r[8];
            d0 = r[2] - r[6]; d1 = r[1] + r[3]; d2 = r[5] + r[7];
        end else begin
            b = 3; rad = (1 << FB) + r[8] - r[0] - r[4];
            d0 = r[3] - r[1]; d1 = r[2] + r[6]; d2 = r[5] + r[7];
        end
        if (rad < 0) rad = 0;
        root = int_sqrt(longint'(rad) << FB);
        s = root << 1;
        q = '{0, 0, 0, 0};
        if (s != 0) begin
            lead = sat_field((root + 1) >> 1);
            o[0] = div_round(d0, s);
            o[1] = div_round(d1, s);
            o[2] = div_round(d2, s);
            q[b] = lead;
            j = 0;
            for (int k = 0; k < 4; k++) begin
                if (k != b) begin
                    q[k] = o[j];
                    j++;
                end
            end
        end
        res.w = q[0][DW-1:0];
        res.x = q[1][DW-1:0];
        res.y = q[2][DW-1:0];
        res.z = q[3][DW-1:0];
        res.br = branch_t'(b);
        res.degen = (s == 0);
        return res;
    endfunction

    class quat_scoreboard;
        quat_t pending[$];

        function void note_matrix(logic [SW-1:0] m);
            pending.push_back(matrix_to_quat(m));
        endfunction

        task check_quat(logic [MW-1:0] d);
            quat_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", longint'(d[63:0]), 0);
                return;
            end
            e = pending.pop_front();
            if ($signed(d[0 +: DW]) != e.w) report_mismatch("quat_w", $signed(d[0 +: DW]), e.w);
            if ($signed(d[DW +: DW]) != e.x)
                report_mismatch("quat_x", $signed(d[DW +: DW]), e.x);
            if ($signed(d[2*DW +: DW]) != e.y)
                report_mismatch("quat_y", $signed(d[2*DW +: DW]), e.y);
            if ($signed(d[3*DW +: DW]) != e.z)
                report_mismatch("quat_z", $signed(d[3*DW +: DW]), e.z);
            if (d[4*DW +: 2] != e.br) report_mismatch("branch_used", d[4*DW +: 2], e.br);
            if (d[4*DW+2] != e.degen) report_mismatch("degenerate", d[4*DW+2], e.degen);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;

    quat_scoreboard sb = new();
    bit calm = 1'b0;
    bit long_stall = 1'b0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    rotation_matrix_to_quaternion_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_matrix(s_tdata);
            if (m_tvalid && m_tready) sb.check_quat(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_stall) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_stall = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_matrix(input logic [SW-1:0] m);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= m;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [SW-1:0] pack9(input longint e[9]);
        logic [SW-1:0] m;
        m = '0;
        for (int i = 0; i < 9; i++) m[i*DW +: DW] = e[i][DW-1:0];
        return m;
    endfunction

    // rotation-like matrix: axis permutation with signs, plus noise
    function automatic logic [SW-1:0] near_rotation(input int noise);
        longint e[9];
        int p[3];
        int t, a;
        p = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            a = $urandom_range(0, i);
            t = p[i]; p[i] = p[a]; p[a] = t;
        end
        for (int i = 0; i < 9; i++) e[i] = 0;
        for (int i = 0; i < 3; i++) e[i*3 + p[i]] = $urandom_range(0, 1) ? 16384 : -16384;
        for (int i = 0; i < 9; i++)
            e[i] = sat_field(e[i] + longint'($urandom_range(0, 2*noise)) - noise);
        return pack9(e);
    endfunction

    function automatic logic [SW-1:0] random_matrix();
        logic [SW-1:0] m;
        for (int i = 0; i < SW/16; i++) m[i*16 +: 16] = 16'($urandom);
        return m;
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, branch rotations, ties, extremes, degenerate
        send_matrix(pack9('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}));
        send_matrix(pack9('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}));
        send_matrix(pack9('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}));
        send_matrix(pack9('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}));
        send_matrix(pack9('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}));
        send_matrix(pack9('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_matrix(pack9('{-100, 5, 6, 7, -100, 8, 9, 10, -200}));
        send_matrix(pack9('{-200, 5, 6, 7, -100, 8, 9, 10, -100}));
        send_matrix(pack9('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
        send_matrix(pack9('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768}));
        send_matrix(pack9('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                            -32768}));
        send_matrix(pack9('{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 0}));
        send_matrix(pack9('{1, 32767, -32768, -32768, -1, 32767, 32767, -32768, 0}));
        send_matrix(pack9('{0, 0, 0, 0, 0, 0, 0, 0, 1}));
        send_matrix(pack9('{-8192, 0, 0, 0, -8192, 0, 0, 0, 0}));
        send_matrix(pack9('{-16384, 32767, 32767, -32768, 16384, 0, 0, 0, -32768}));
        send_matrix(pack9('{16384, -32768, 32767, 0, 0, 32767, -32768, 0, 0}));
        end_burst();

        // long output stall while the input keeps coming
        long_stall = 1'b1;
        for (int i = 0; i < 120; i++) send_matrix(near_rotation(2000));
        end_burst();
        // drain pause
        wait (sb.pending.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 250) calm = 1'b1;
            if ($urandom_range(0, 9) < 7) send_matrix(near_rotation($urandom_range(0, 20000)));
            else send_matrix(random_matrix());
        end
        end_burst();

        fork
            wait (sb.pending.size() == 0);
            begin
                repeat (WATCHDOG) @(posedge aclk);
            end
        join_any
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
